>>> hdl/pde_pkg.sv
// pde_pkg: sizes, read-select codes and the command/status structs
// shared by the controller, the datapath and the top level of the encoder
// depends on nothing
package pde_pkg;

    // sequence limits
    localparam int MAX_VALUES = 64;
    localparam int DIFF_SLOTS = MAX_VALUES - 1;

    // the value width and the widths derived from the limits
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(MAX_VALUES + 1);
    localparam int IDX_W = (DIFF_SLOTS > 1) ? $clog2(DIFF_SLOTS) : 1;
    localparam int PER_W = $clog2(DIFF_SLOTS + 1);

    // which address the store read ports take
    typedef enum logic [1:0] {
        RD_MATCH    = 2'd0,
        RD_FALLBACK = 2'd1,
        RD_FIRST    = 2'd2,
        RD_NEXT     = 2'd3
    } rd_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    take;
        logic    cmp_step;
        logic    report;
        logic    emit;
        logic    rd_en;
        rd_sel_t rd_sel;
    } pde_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic first_diff;
        logic final_in;
        logic final_held;
        logic diff_eq;
        logic k_zero;
        logic emit_last;
        logic out_free;
    } pde_status_t;

endpackage

>>> hdl/periodic_delta_encoder.sv
// periodic_delta_encoder: top level, joins the controller and the datapath
// depends on pde_pkg, pde_ctrl, pde_dpath
//
//   channel | handshake                    | payload
//   --------+------------------------------+----------------------------------------
//   input   | in_valid / in_stall          | sample_value, final_value
//   output  | out_valid / out_stall        | base_value, value_count, period_length,
//           |                              | diff_value, diff_present, run_end,
//           |                              | overflow_flag
//
// from the third item of a sequence on, an item that extends the difference
// sequence is taken in IDLE and then resolved in CMP, where the prefix walk takes
// its fallback steps (under one step per item on average)
// the first two items of a sequence and a dropped item are taken in IDLE alone
// a final item adds a REPORT state, then one result per cycle while out_stall is low
// the output register lets the next item be taken while the last result waits
// reset clears the sequence registers at once; the stores need no clearing pass
module periodic_delta_encoder
    import pde_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    final_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [VAL_W-1:0] base_value,
    output logic [CNT_W-1:0]        value_count,
    output logic [PER_W-1:0]        period_length,
    output logic signed [VAL_W-1:0] diff_value,
    output logic                    diff_present,
    output logic                    run_end,
    output logic                    overflow_flag
);

    pde_cmd_t    cmd;
    pde_status_t status;

    pde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pde_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sample_value  (sample_value),
        .final_value   (final_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .base_value    (base_value),
        .value_count   (value_count),
        .period_length (period_length),
        .diff_value    (diff_value),
        .diff_present  (diff_present),
        .run_end       (run_end),
        .overflow_flag (overflow_flag)
    );

    // a final item always leaves the block busy with its report
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_value) |=> in_stall)
        else $error("final item did not start a report");

    // every result has at least one stored value and a period below the count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (value_count != '0) && (CNT_W'(period_length) < value_count)
            && (value_count <= CNT_W'(MAX_VALUES)))
        else $error("result count or period out of range");

    // a result without a difference is the single result of a zero period
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !diff_present) |-> run_end && (period_length == '0)
            && (diff_value == '0))
        else $error("empty difference result malformed");

endmodule

>>> hdl/pde_ctrl.sv
// pde_ctrl: state machine that sequences take, prefix walk, report and emit
// depends on pde_pkg
module pde_ctrl
    import pde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pde_status_t status,
    output pde_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CMP    = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_MATCH;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_MATCH;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.cnt_zero || status.cnt_full || status.first_diff)
                    begin
                        state_next = status.final_in ? ST_REPORT : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                cmd.cmp_step = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_FALLBACK;
                if (status.diff_eq || status.k_zero)
                begin
                    state_next = status.final_held ? ST_REPORT : ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                cmd.report = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_FIRST;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

>>> hdl/pde_dpath.sv
// pde_dpath: sequence registers, difference and prefix stores, compare,
// period calculation and the output register
// depends on pde_pkg
module pde_dpath
    import pde_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pde_cmd_t                cmd,
    output pde_status_t             status,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    final_value,
    input  logic                    out_stall,
    output logic                    out_valid,
    output logic signed [VAL_W-1:0] base_value,
    output logic [CNT_W-1:0]        value_count,
    output logic [PER_W-1:0]        period_length,
    output logic signed [VAL_W-1:0] diff_value,
    output logic                    diff_present,
    output logic                    run_end,
    output logic                    overflow_flag
);

    // sequence state
    logic [VAL_W-1:0] first_reg;
    logic [VAL_W-1:0] prev_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] match_reg;
    logic             ovf_reg;

    // per-item working registers
    logic [VAL_W-1:0] d_reg;
    logic [IDX_W-1:0] k_reg;
    logic             final_reg;
    logic [PER_W-1:0] period_reg;
    logic [IDX_W-1:0] j_reg;

    // stores and their registered read data
    logic [VAL_W-1:0] diff_mem [0:DIFF_SLOTS-1];
    logic [IDX_W-1:0] pfx_mem  [0:DIFF_SLOTS-1];
    logic [VAL_W-1:0] diff_rd_reg;
    logic [IDX_W-1:0] pfx_rd_reg;

    // output register
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_base_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [PER_W-1:0] out_period_reg;
    logic [VAL_W-1:0] out_diff_reg;
    logic             out_present_reg;
    logic             out_end_reg;
    logic             out_ovf_reg;

    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] d_new;
    logic [IDX_W-1:0] k_inc;
    logic             diff_eq;
    logic             k_zero;
    logic             resolve;
    logic             diff_we;
    logic             pfx_we;
    logic [IDX_W-1:0] pfx_wdata;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] pfx_addr;
    logic [PER_W-1:0] period_calc;
    logic             period_zero;
    logic             emit_last;
    logic             out_free;
    logic             cnt_zero;
    logic             cnt_full;
    logic             first_diff;

    // status decode
    assign wr_idx      = IDX_W'(count_reg - CNT_W'(1));
    assign d_new       = sample_value - prev_reg;
    assign k_inc       = k_reg + IDX_W'(1);
    assign diff_eq     = (d_reg == diff_rd_reg);
    assign k_zero      = (k_reg == '0);
    assign resolve     = cmd.cmp_step && (diff_eq || k_zero);
    assign cnt_zero    = (count_reg == '0);
    assign cnt_full    = (count_reg >= CNT_W'(MAX_VALUES));
    assign first_diff  = (count_reg == CNT_W'(1));
    assign period_calc = PER_W'(count_reg - CNT_W'(1)) - PER_W'(match_reg);
    assign period_zero = (period_reg == '0);
    assign emit_last   = period_zero || ((PER_W'(j_reg) + PER_W'(1)) == period_reg);
    assign out_free    = !out_valid_reg || !out_stall;

    assign status.cnt_zero   = cnt_zero;
    assign status.cnt_full   = cnt_full;
    assign status.first_diff = first_diff;
    assign status.final_in   = final_value;
    assign status.final_held = final_reg;
    assign status.diff_eq    = diff_eq;
    assign status.k_zero     = k_zero;
    assign status.emit_last  = emit_last;
    assign status.out_free   = out_free;

    // store write enables and data
    assign diff_we   = cmd.take && !cnt_zero && !cnt_full;
    assign pfx_we    = (cmd.take && !cnt_zero && !cnt_full && first_diff) || resolve;
    assign pfx_wdata = (cmd.cmp_step && diff_eq) ? k_inc : '0;

    // read address select, prefix port reads entry k-1
    always_comb
    begin
        case (cmd.rd_sel)
            RD_MATCH:    rd_addr = match_reg;
            RD_FALLBACK: rd_addr = pfx_rd_reg;
            RD_FIRST:    rd_addr = '0;
            RD_NEXT:     rd_addr = j_reg + IDX_W'(1);
            default:     rd_addr = match_reg;
        endcase
    end

    assign pfx_addr = rd_addr - IDX_W'(1);

    // difference and prefix stores
    always_ff @(posedge clk)
    begin
        if (diff_we)
        begin
            diff_mem[wr_idx] <= d_new;
        end
        if (pfx_we)
        begin
            pfx_mem[wr_idx] <= pfx_wdata;
        end
        if (cmd.rd_en)
        begin
            diff_rd_reg <= diff_mem[rd_addr];
            pfx_rd_reg  <= pfx_mem[pfx_addr];
        end
    end

    // sequence state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            match_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                if (cnt_zero)
                begin
                    first_reg <= sample_value;
                    prev_reg  <= sample_value;
                    count_reg <= CNT_W'(1);
                end
                else if (cnt_full)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    prev_reg <= sample_value;
                    if (first_diff)
                    begin
                        match_reg <= '0;
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
            end
            if (resolve)
            begin
                match_reg <= diff_eq ? k_inc : '0;
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.emit && emit_last)
            begin
                first_reg <= '0;
                prev_reg  <= '0;
                count_reg <= '0;
                match_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            final_reg <= final_value;
            d_reg     <= d_new;
            k_reg     <= match_reg;
        end
        if (cmd.cmp_step && !diff_eq && !k_zero)
        begin
            k_reg <= pfx_rd_reg;
        end
        if (cmd.report)
        begin
            period_reg <= period_calc;
            j_reg      <= '0;
        end
        if (cmd.emit)
        begin
            j_reg           <= j_reg + IDX_W'(1);
            out_base_reg    <= first_reg;
            out_count_reg   <= count_reg;
            out_period_reg  <= period_reg;
            out_diff_reg    <= period_zero ? '0 : diff_rd_reg;
            out_present_reg <= !period_zero;
            out_end_reg     <= emit_last;
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign base_value    = out_base_reg;
    assign value_count   = out_count_reg;
    assign period_length = out_period_reg;
    assign diff_value    = out_diff_reg;
    assign diff_present  = out_present_reg;
    assign run_end       = out_end_reg;
    assign overflow_flag = out_ovf_reg;

endmodule
